// ===== design/siphash32_pkg.sv =====
// ----------------------------------------------------------------------------
// SipHash 32-bit word unit package
// Lane type, lane constants and the two half-rounds of the SipHash mix.
// ----------------------------------------------------------------------------
package siphash32_pkg;

    typedef logic [3:0][63:0] lanes_t;

    localparam logic [63:0] LANE_INIT0 = 64'h736f6d6570736575;
    localparam logic [63:0] LANE_INIT1 = 64'h646f72616e646f6d;
    localparam logic [63:0] LANE_INIT2 = 64'h6c7967656e657261;
    localparam logic [63:0] LANE_INIT3 = 64'h7465646279746573;
    localparam logic [63:0] FINAL_MARK = 64'h00000000000000ff;
    localparam logic [7:0]  BLOCK_LEN  = 8'd4;

    localparam int WORD_W = 32;
    // Two compression rounds and four finalization rounds, two stages each.
    localparam int COMP_STAGES = 4;
    localparam int NUM_STAGES  = 12;

    function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned n);
        rotl64 = (x << n) | (x >> (64 - n));
    endfunction

    // First half of a round: one add per lane pair, then rotate and xor.
    function automatic lanes_t half_a(input lanes_t s);
        lanes_t r;
        r = s;
        r[0] = r[0] + r[1];
        r[2] = r[2] + r[3];
        r[1] = rotl64(r[1], 13) ^ r[0];
        r[3] = rotl64(r[3], 16) ^ r[2];
        r[0] = rotl64(r[0], 32);
        return r;
    endfunction

    function automatic lanes_t half_b(input lanes_t s);
        lanes_t r;
        r = s;
        r[2] = r[2] + r[1];
        r[0] = r[0] + r[3];
        r[1] = rotl64(r[1], 17) ^ r[2];
        r[3] = rotl64(r[3], 21) ^ r[0];
        r[2] = rotl64(r[2], 32);
        return r;
    endfunction

endpackage

// ===== design/siphash_fixed_32bit_message_unit.sv =====
// ----------------------------------------------------------------------------
// SipHash-2-4 unit for single 32-bit words
// Hashes one word per beat under a 32-bit key held in a register.
// ----------------------------------------------------------------------------
//  Channel   Dir   Bits  Contents
//  s_axis    in    32    message_word
//  m_axis    out   32    hash_value
//  cfg       in    32    hash_key
//
// One word enters per cycle unless a held output has backed up the pipe to the input.
// The twelve stages are the half-rounds of the mix, one 64-bit add per lane
// pair in each, with the last stage folding the lanes into the hash.
// Each stage keeps its beat while the next one is full and stalled, so a
// held output fills the pipe stage by stage; bubbles close up.
// Reset clears all valid bits and the key to zero.
module siphash_fixed_32bit_message_unit
    import siphash32_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [WORD_W-1:0] s_tdata,   // [31:0] message_word
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [WORD_W-1:0] m_tdata,   // [31:0] hash_value
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [WORD_W-1:0] cfg_data
);

    logic [WORD_W-1:0] key_reg;
    logic              valid_reg [NUM_STAGES];
    lanes_t            lanes_reg [NUM_STAGES-1];
    logic [WORD_W-1:0] word_reg  [COMP_STAGES];
    logic [WORD_W-1:0] hash_reg;

    logic              adv       [NUM_STAGES];
    lanes_t            lanes_next[NUM_STAGES];
    logic [WORD_W-1:0] hash_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else if (cfg_valid) begin
            key_reg <= cfg_data;
        end
    end

    // A stage may load when it is empty or its beat moves on this cycle.
    always_comb begin
        adv[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_tready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    assign s_tready = adv[0];

    always_comb begin
        lanes_t            st;
        logic [63:0]       blk;
        logic [63:0]       key64;
        key64 = {{(64-WORD_W){1'b0}}, key_reg};
        blk   = {BLOCK_LEN, 24'd0, s_tdata};
        st[0] = LANE_INIT0;
        st[1] = LANE_INIT1 ^ key64;
        st[2] = LANE_INIT2;
        st[3] = LANE_INIT3 ^ key64 ^ blk;
        lanes_next[0] = half_a(st);
        for (int i = 1; i < NUM_STAGES; i++) begin
            if (i == COMP_STAGES) begin
                // Compression done: close the block and mark finalization.
                blk   = {BLOCK_LEN, 24'd0, word_reg[COMP_STAGES-1]};
                st    = lanes_reg[i-1];
                st[0] = st[0] ^ blk;
                st[2] = st[2] ^ FINAL_MARK;
            end else begin
                st = lanes_reg[i-1];
            end
            lanes_next[i] = (i % 2 == 0) ? half_a(st) : half_b(st);
        end
        hash_next = lanes_next[NUM_STAGES-1][0][WORD_W-1:0]
                  ^ lanes_next[NUM_STAGES-1][1][WORD_W-1:0]
                  ^ lanes_next[NUM_STAGES-1][2][WORD_W-1:0]
                  ^ lanes_next[NUM_STAGES-1][3][WORD_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_STAGES; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else begin
            if (adv[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NUM_STAGES; i++) begin
                if (adv[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NUM_STAGES - 1; i++) begin
            if (adv[i]) begin
                lanes_reg[i] <= lanes_next[i];
            end
        end
        if (adv[0]) begin
            word_reg[0] <= s_tdata;
        end
        for (int i = 1; i < COMP_STAGES; i++) begin
            if (adv[i]) begin
                word_reg[i] <= word_reg[i-1];
            end
        end
        if (adv[NUM_STAGES-1]) begin
            hash_reg <= hash_next;
        end
    end

    assign m_tvalid = valid_reg[NUM_STAGES-1];
    assign m_tdata  = hash_reg;

endmodule

// ===== design/siphash32_checker.sv =====
// ----------------------------------------------------------------------------
// SipHash 32-bit word unit checker
// Port-level assertions on the hash unit, bound to the top level.
// ----------------------------------------------------------------------------
module siphash32_checker
    import siphash32_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [WORD_W-1:0] m_tdata,
    input logic              cfg_valid,
    input logic              cfg_ready
);

    // A held result beat keeps its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // The input side only backs up when every stage is full behind a stalled output.
    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without an output stall");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // The key register never pushes back.
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("key write refused");

endmodule

bind siphash_fixed_32bit_message_unit siphash32_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Testbench for the SipHash-2-4 32-bit word unit
// Streams message words under a series of keys and checks every hash beat
// against a predictor of the hash, with random gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import siphash32_pkg::*;

    typedef logic [3:0][63:0] lane_set_t;

    typedef struct {
        logic [31:0] word;
        logic [31:0] key;
        logic [31:0] hash;
    } hash_entry_t;

    class hash_checker;
        hash_entry_t pending_q[$];
        logic [31:0] key;
        int          mismatches;
        int          checked;
        int          noted;

        function new();
            key        = '0;
            mismatches = 0;
            checked    = 0;
            noted      = 0;
        endfunction

        static function logic [63:0] rotl(input logic [63:0] x, input int n);
            return (x << n) | (x >> (64 - n));
        endfunction

        static function lane_set_t sip_round(input lane_set_t v);
            v[0] = v[0] + v[1];
            v[2] = v[2] + v[3];
            v[1] = rotl(v[1], 13) ^ v[0];
            v[3] = rotl(v[3], 16) ^ v[2];
            v[0] = rotl(v[0], 32);
            v[2] = v[2] + v[1];
            v[0] = v[0] + v[3];
            v[1] = rotl(v[1], 17) ^ v[2];
            v[3] = rotl(v[3], 21) ^ v[0];
            v[2] = rotl(v[2], 32);
            return v;
        endfunction

        static function logic [31:0] hash_of(input logic [31:0] word, input logic [31:0] k);
            lane_set_t   v;
            logic [63:0] blk;
            logic [63:0] folded;
            // The byte count sits in the top byte of the single message block.
            blk  = {BLOCK_LEN, 24'd0, word};
            v[0] = LANE_INIT0;
            v[1] = LANE_INIT1 ^ {32'd0, k};
            v[2] = LANE_INIT2;
            v[3] = LANE_INIT3 ^ {32'd0, k};
            v[3] = v[3] ^ blk;
            repeat (2) v = sip_round(v);
            v[0] = v[0] ^ blk;
            v[2] = v[2] ^ FINAL_MARK;
            repeat (4) v = sip_round(v);
            folded = v[0] ^ v[1] ^ v[2] ^ v[3];
            return folded[31:0];
        endfunction

        function void set_key(input logic [31:0] k);
            key = k;
        endfunction

        function void note_word(input logic [31:0] word);
            hash_entry_t e;
            e.word = word;
            e.key  = key;
            e.hash = hash_of(word, key);
            pending_q.push_back(e);
            noted++;
        endfunction

        function void check_hash(input logic [31:0] actual);
            hash_entry_t e;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: hash %h arrived with no word pending", actual);
            end else begin
                e = pending_q.pop_front();
                checked++;
                if (actual !== e.hash) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: word %h key %h: expected hash %h, got %h",
                                 e.word, e.key, e.hash, actual);
                end
            end
        endfunction

        function int pending();
            return pending_q.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    hash_checker sb;

    int rx_beats;
    int hold_left;
    int next_hold;
    int stall_mode;
    int mode_cycles;
    int holds_seen;
    int keys_written;

    siphash_fixed_32bit_message_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Hash beats are checked as they are accepted.
    always @(posedge aclk) begin
        if (aresetn && sb != null && m_tvalid && m_tready)
            sb.check_hash(m_tdata);
    end

    // Output back-pressure: the stall pattern changes now and then, and after
    // a set number of hash beats the receiver holds off long enough for the
    // pipeline to fill and push back on the input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready    <= 1'b0;
            rx_beats    = 0;
            hold_left   = 0;
            next_hold   = 150;
            stall_mode  = 0;
            mode_cycles = 0;
            holds_seen  = 0;
        end else begin
            if (m_tvalid && m_tready)
                rx_beats++;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (rx_beats >= next_hold) begin
                hold_left = 63;
                next_hold += 250;
                holds_seen++;
                m_tready <= 1'b0;
            end else begin
                mode_cycles++;
                if (mode_cycles >= 97) begin
                    mode_cycles = 0;
                    stall_mode  = $urandom_range(0, 3);
                end
                case (stall_mode)
                    0: begin
                        m_tready <= 1'b1;
                    end
                    1: begin
                        m_tready <= ($urandom_range(0, 1) != 0);
                    end
                    2: begin
                        m_tready <= (mode_cycles % 8) < 5;
                    end
                    default: begin
                        m_tready <= $urandom_range(0, 3) != 0;
                    end
                endcase
            end
        end
    end

    task automatic send_word(input logic [31:0] word);
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        sb.note_word(word);
    endtask

    task automatic write_key(input logic [31:0] k);
        cfg_valid <= 1'b1;
        cfg_data  <= k;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        sb.set_key(k);
        keys_written++;
    endtask

    // The key may only change once the pipeline has drained.
    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 7))
            0: return 32'd1 << $urandom_range(0, 31);
            1: return ~(32'd1 << $urandom_range(0, 31));
            2: return $urandom_range(0, 255);
            3: return 32'hffff_ffff - $urandom_range(0, 255);
            default: return $urandom();
        endcase
    endfunction

    task automatic send_random(input int count);
        int burst_left;
        int gap;
        burst_left = 0;
        for (int i = 0; i < count; i++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            send_word(random_word());
            burst_left--;
        end
        s_tvalid <= 1'b0;
    endtask

    initial begin
        logic [31:0] edge_words[12];
        logic [31:0] phase_keys[6];
        sb           = new();
        keys_written = 0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        edge_words = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_0001, 32'h8000_0000,
                       32'h7fff_ffff, 32'h5555_5555, 32'haaaa_aaaa, 32'h0000_ffff,
                       32'hffff_0000, 32'h0000_00ff, 32'hff00_0000, 32'h1234_5678};

        // First with the key left at its reset value, then under the all-ones key.
        foreach (edge_words[i])
            send_word(edge_words[i]);
        s_tvalid <= 1'b0;
        wait_drained();
        write_key(32'hffff_ffff);
        for (int i = 0; i < 8; i++)
            send_word(edge_words[i]);
        s_tvalid <= 1'b0;

        phase_keys = '{32'h0000_0001, 32'h8000_0000, $urandom(), $urandom(),
                       32'h0000_0000, $urandom()};
        foreach (phase_keys[p]) begin
            wait_drained();
            write_key(phase_keys[p]);
            send_random(105);
        end

        while (sb.pending() != 0) @(posedge aclk);
        repeat (24) @(posedge aclk);

        $display("Hashed %0d words under %0d key writes plus the reset key; %0d hashes checked.",
                 sb.noted, keys_written, sb.checked);
        $display("Output hold-offs: %0d, mismatches: %0d, hashes still pending: %0d.",
                 holds_seen, sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
